[hdl/wso_pkg.sv]
// ----------------------------------------------------------------------------
// wso_pkg
// Shared widths, constants and divider request/response types for the
// wheel speed odometer.
// ----------------------------------------------------------------------------
package wso_pkg;

    localparam int TICKS_W  = 16;
    localparam int CIRC_W   = 13;
    localparam int RESULT_W = 20;
    localparam int TOTAL_W  = 40;
    localparam int NUM_W    = TOTAL_W + 7;
    localparam int CNT_W    = $clog2(RESULT_W);

    localparam logic [TICKS_W-1:0]  TICKS_STOPPED = '1;
    localparam logic [CIRC_W-1:0]   CIRC_RESET    = CIRC_W'(2230);
    localparam logic [RESULT_W-1:0] RESULT_MAX    = '1;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX     = '1;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] num;
        logic [TOTAL_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [RESULT_W-1:0] quot;
    } div_rsp_t;

endpackage

[hdl/wso_divider.sv]
// ----------------------------------------------------------------------------
// wso_divider
// Iterative restoring divider computing min(num*72/den, 2^20-1), one
// quotient bit per cycle after a scale step and an overflow check.
// ----------------------------------------------------------------------------
module wso_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  wso_pkg::div_req_t req,
    output wso_pkg::div_rsp_t rsp
);

    typedef enum logic [2:0] {
        D_IDLE,
        D_SCALE,
        D_CHECK,
        D_ITER,
        D_DONE
    } div_state_t;

    div_state_t                         state_reg;
    logic [wso_pkg::TOTAL_W-1:0]        x_reg;
    logic [wso_pkg::TOTAL_W-1:0]        den_reg;
    logic [wso_pkg::NUM_W-1:0]          n_reg;
    logic [wso_pkg::TOTAL_W-1:0]        rem_reg;
    logic [wso_pkg::RESULT_W-1:0]       low_reg;
    logic [wso_pkg::CNT_W-1:0]          cnt_reg;

    logic [wso_pkg::NUM_W-1:0]          scaled;
    logic [wso_pkg::TOTAL_W-1:0]        high_part;
    logic [wso_pkg::TOTAL_W:0]          trial;
    logic [wso_pkg::TOTAL_W:0]          diff;
    logic                               qbit;

    // x*72 as x*64 + x*8
    assign scaled = {1'b0, x_reg, 6'b0} + {4'b0, x_reg, 3'b0};
    assign high_part = wso_pkg::TOTAL_W'(n_reg[wso_pkg::NUM_W-1:wso_pkg::RESULT_W]);
    assign trial = {rem_reg, low_reg[wso_pkg::RESULT_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        x_reg     <= req.num;
                        den_reg   <= req.den;
                        state_reg <= D_SCALE;
                    end
                end
                D_SCALE:
                begin
                    n_reg     <= scaled;
                    state_reg <= D_CHECK;
                end
                D_CHECK:
                begin
                    // quotient too large (or zero divisor) saturates
                    if (high_part >= den_reg)
                    begin
                        low_reg   <= wso_pkg::RESULT_MAX;
                        state_reg <= D_DONE;
                    end
                    else
                    begin
                        rem_reg   <= high_part;
                        low_reg   <= n_reg[wso_pkg::RESULT_W-1:0];
                        cnt_reg   <= '0;
                        state_reg <= D_ITER;
                    end
                end
                D_ITER:
                begin
                    rem_reg <= qbit ? diff[wso_pkg::TOTAL_W-1:0]
                                    : trial[wso_pkg::TOTAL_W-1:0];
                    low_reg <= {low_reg[wso_pkg::RESULT_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == wso_pkg::CNT_W'(wso_pkg::RESULT_W - 1))
                    begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE:
                begin
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = (state_reg == D_DONE);
    assign rsp.quot = low_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (state_reg == D_IDLE))
        else $error("divider started while busy");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_ITER) |-> (cnt_reg < wso_pkg::CNT_W'(wso_pkg::RESULT_W)))
        else $error("divider iteration count out of range");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_ITER) |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

endmodule

[hdl/wheel_speed_odometer.sv]
// ----------------------------------------------------------------------------
// wheel_speed_odometer
// Bicycle speedometer and odometer over one shared iterative divider.
// ----------------------------------------------------------------------------
// Input channel: rotation_ticks with in_valid/in_stall, one wheel revolution
// time in 5 ms ticks; 65535 marks a stopped wheel. Each request yields
// exactly one result on the output channel (out_valid/out_stall) carrying
// current speed, average speed, total distance, total duration and an
// updated flag.
// Configuration: wheel_circumference_mm with cfg_valid/cfg_ready, always
// ready; write only while the block is idle.
// Sequence: a stopped-wheel or first-revolution request goes straight to the
// output register stage; a counted revolution first updates the totals, then
// runs the divider twice back to back, for speed then average (scale,
// overflow check, 20 quotient bits, done), skipping the quotient bits when a
// quotient saturates. in_stall stays high until the result has been loaded
// into the output register, so a new request is taken only after the
// previous result has been loaded.
// Reset clears the totals, the held speeds and the first-turn flag and
// loads a circumference of 2230 mm. If the receiver stalls, the result
// holds in the output register and a following request is computed but
// waits to be loaded until the pending result is taken.
// ----------------------------------------------------------------------------
module wheel_speed_odometer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [wso_pkg::TICKS_W-1:0]    rotation_ticks,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wso_pkg::RESULT_W-1:0]   speed_centi_kmh,
    output logic [wso_pkg::RESULT_W-1:0]   average_centi_kmh,
    output logic [wso_pkg::TOTAL_W-1:0]    distance_mm,
    output logic [wso_pkg::TOTAL_W-1:0]    duration_ticks,
    output logic                           updated,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wso_pkg::CIRC_W-1:0]     wheel_circumference_mm
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_SPEED,
        S_SPEED_WAIT,
        S_AVG,
        S_AVG_WAIT,
        S_FINISH
    } seq_state_t;

    seq_state_t                      state_reg;
    logic [wso_pkg::CIRC_W-1:0]      circ_reg;
    logic [wso_pkg::TICKS_W-1:0]     ticks_reg;
    logic                            first_seen_reg;
    logic [wso_pkg::TOTAL_W-1:0]     dist_reg;
    logic [wso_pkg::TOTAL_W-1:0]     dur_reg;
    logic [wso_pkg::RESULT_W-1:0]    speed_reg;
    logic [wso_pkg::RESULT_W-1:0]    avg_reg;
    logic                            upd_reg;

    logic                            out_valid_reg;
    logic [wso_pkg::RESULT_W-1:0]    out_speed_reg;
    logic [wso_pkg::RESULT_W-1:0]    out_avg_reg;
    logic [wso_pkg::TOTAL_W-1:0]     out_dist_reg;
    logic [wso_pkg::TOTAL_W-1:0]     out_dur_reg;
    logic                            out_upd_reg;

    logic [wso_pkg::TOTAL_W:0]       dist_sum;
    logic [wso_pkg::TOTAL_W:0]       dur_sum;
    logic [wso_pkg::TOTAL_W-1:0]     dist_next;
    logic [wso_pkg::TOTAL_W-1:0]     dur_next;
    logic                            in_take;
    logic                            out_free;

    wso_pkg::div_req_t               div_req;
    wso_pkg::div_rsp_t               div_rsp;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    // saturating totals
    assign dist_sum  = {1'b0, dist_reg} + (wso_pkg::TOTAL_W + 1)'(circ_reg);
    assign dur_sum   = {1'b0, dur_reg} + (wso_pkg::TOTAL_W + 1)'(ticks_reg);
    assign dist_next = dist_sum[wso_pkg::TOTAL_W] ? wso_pkg::TOTAL_MAX
                                                  : dist_sum[wso_pkg::TOTAL_W-1:0];
    assign dur_next  = dur_sum[wso_pkg::TOTAL_W] ? wso_pkg::TOTAL_MAX
                                                 : dur_sum[wso_pkg::TOTAL_W-1:0];

    always_comb
    begin
        div_req.start = (state_reg == S_SPEED) || (state_reg == S_AVG);
        if (state_reg == S_AVG)
        begin
            div_req.num = dist_reg;
            div_req.den = dur_reg;
        end
        else
        begin
            div_req.num = wso_pkg::TOTAL_W'(circ_reg);
            div_req.den = wso_pkg::TOTAL_W'(ticks_reg);
        end
    end

    wso_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_reg <= wso_pkg::CIRC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            circ_reg <= wheel_circumference_mm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_seen_reg <= 1'b0;
            dist_reg       <= '0;
            dur_reg        <= '0;
            speed_reg      <= '0;
            avg_reg        <= '0;
            upd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        ticks_reg <= rotation_ticks;
                        priority if (rotation_ticks == wso_pkg::TICKS_STOPPED)
                        begin
                            speed_reg <= '0;
                            upd_reg   <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                        else if (!first_seen_reg)
                        begin
                            first_seen_reg <= 1'b1;
                            upd_reg        <= 1'b0;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            upd_reg   <= 1'b1;
                            state_reg <= S_ACCUM;
                        end
                    end
                end
                S_ACCUM:
                begin
                    dist_reg  <= dist_next;
                    dur_reg   <= dur_next;
                    state_reg <= S_SPEED;
                end
                S_SPEED:
                begin
                    state_reg <= S_SPEED_WAIT;
                end
                S_SPEED_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        speed_reg <= div_rsp.quot;
                        state_reg <= S_AVG;
                    end
                end
                S_AVG:
                begin
                    state_reg <= S_AVG_WAIT;
                end
                S_AVG_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        avg_reg   <= div_rsp.quot;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_speed_reg <= speed_reg;
                        out_avg_reg   <= avg_reg;
                        out_dist_reg  <= dist_reg;
                        out_dur_reg   <= dur_reg;
                        out_upd_reg   <= upd_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign speed_centi_kmh   = out_speed_reg;
    assign average_centi_kmh = out_avg_reg;
    assign distance_mm       = out_dist_reg;
    assign duration_ticks    = out_dur_reg;
    assign updated           = out_upd_reg;

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_SPEED_WAIT || state_reg == S_AVG_WAIT))
        else $error("divider result arrived outside a wait state");

    a_first_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(first_seen_reg))
        else $error("first-turn flag cleared");

    a_stopped_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && rotation_ticks == wso_pkg::TICKS_STOPPED) |=> (speed_reg == '0))
        else $error("stopped wheel did not clear speed");

    a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACCUM) |=> (dist_reg >= $past(dist_reg) && dur_reg >= $past(dur_reg)))
        else $error("totals decreased");

endmodule

[tb/wheel_speed_odometer_tb.sv]
// ----------------------------------------------------------------------------
// wheel_speed_odometer_tb
// Self-checking bench for the wheel speed odometer. A queue of revolution
// times feeds a clocked driver; every accepted request is run through a
// local ride computer that predicts speed, average and totals, and a clocked
// monitor compares each result against the oldest prediction. Circumference
// is rewritten between phases once the block has drained.
// ----------------------------------------------------------------------------
module wheel_speed_odometer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 37;

    typedef struct {
        logic [wso_pkg::RESULT_W-1:0] speed;
        logic [wso_pkg::RESULT_W-1:0] average;
        logic [wso_pkg::TOTAL_W-1:0]  distance;
        logic [wso_pkg::TOTAL_W-1:0]  duration;
        logic                         advanced;
    } odo_reading_t;

    logic                         clk                    = 1'b0;
    logic                         rst_n                  = 1'b0;
    logic                         in_valid               = 1'b0;
    logic                         in_stall;
    logic [wso_pkg::TICKS_W-1:0]  rotation_ticks         = '0;
    logic                         out_valid;
    logic                         out_stall              = 1'b0;
    logic [wso_pkg::RESULT_W-1:0] speed_centi_kmh;
    logic [wso_pkg::RESULT_W-1:0] average_centi_kmh;
    logic [wso_pkg::TOTAL_W-1:0]  distance_mm;
    logic [wso_pkg::TOTAL_W-1:0]  duration_ticks;
    logic                         updated;
    logic                         cfg_valid              = 1'b0;
    logic                         cfg_ready;
    logic [wso_pkg::CIRC_W-1:0]   wheel_circumference_mm = wso_pkg::CIRC_RESET;

    logic [wso_pkg::TICKS_W-1:0]  revolutions_pending[$];
    odo_reading_t                 readings_due[$];

    // ride computer state
    logic [wso_pkg::CIRC_W-1:0]   circ_setting  = wso_pkg::CIRC_RESET;
    logic                         turn_noted    = 1'b0;
    logic [wso_pkg::TOTAL_W-1:0]  ride_distance = '0;
    logic [wso_pkg::TOTAL_W-1:0]  ride_ticks    = '0;
    logic [wso_pkg::RESULT_W-1:0] speed_now     = '0;
    logic [wso_pkg::RESULT_W-1:0] speed_avg     = '0;

    int errors        = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int idle_cycles   = 0;

    wheel_speed_odometer DUT (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_stall               (in_stall),
        .rotation_ticks         (rotation_ticks),
        .out_valid              (out_valid),
        .out_stall              (out_stall),
        .speed_centi_kmh        (speed_centi_kmh),
        .average_centi_kmh      (average_centi_kmh),
        .distance_mm            (distance_mm),
        .duration_ticks         (duration_ticks),
        .updated                (updated),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .wheel_circumference_mm (wheel_circumference_mm)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [wso_pkg::TOTAL_W-1:0] saturating_sum(
        input logic [wso_pkg::TOTAL_W-1:0] acc,
        input logic [wso_pkg::TOTAL_W-1:0] inc);
        logic [63:0] sum;
        begin
            sum = 64'(acc) + 64'(inc);
            return (sum > 64'(wso_pkg::TOTAL_MAX)) ? wso_pkg::TOTAL_MAX
                                                   : sum[wso_pkg::TOTAL_W-1:0];
        end
    endfunction

    // speed in 0.01 km/h from millimetres over 5 ms ticks
    function automatic logic [wso_pkg::RESULT_W-1:0] centi_kmh(input logic [63:0] mm,
                                                               input logic [63:0] ticks);
        logic [63:0] quot;
        begin
            if (ticks == 0)
                return wso_pkg::RESULT_MAX;
            quot = (mm * 64'd72) / ticks;
            return (quot > 64'(wso_pkg::RESULT_MAX)) ? wso_pkg::RESULT_MAX
                                                     : quot[wso_pkg::RESULT_W-1:0];
        end
    endfunction

    function automatic odo_reading_t advance_ride(input logic [wso_pkg::TICKS_W-1:0] ticks);
        odo_reading_t reading;
        begin
            reading.advanced = 1'b0;
            if (ticks == wso_pkg::TICKS_STOPPED)
                speed_now = '0;
            else if (!turn_noted)
                turn_noted = 1'b1;
            else
            begin
                ride_ticks    = saturating_sum(ride_ticks, wso_pkg::TOTAL_W'(ticks));
                ride_distance = saturating_sum(ride_distance,
                                               wso_pkg::TOTAL_W'(circ_setting));
                speed_now     = centi_kmh(64'(circ_setting), 64'(ticks));
                speed_avg     = centi_kmh(64'(ride_distance), 64'(ride_ticks));
                reading.advanced = 1'b1;
            end
            reading.speed    = speed_now;
            reading.average  = speed_avg;
            reading.distance = ride_distance;
            reading.duration = ride_ticks;
            return reading;
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                readings_due.push_back(advance_ride(rotation_ticks));
                requests_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (revolutions_pending.size() != 0 &&
                    ((requests_sent >= 350 && requests_sent < 450) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid       <= 1'b1;
                    rotation_ticks <= revolutions_pending.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        odo_reading_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual speed %0d distance %0d",
                             $time, speed_centi_kmh, distance_mm);
                    errors++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    check_field("speed_centi_kmh", 64'(want.speed), 64'(speed_centi_kmh));
                    check_field("average_centi_kmh", 64'(want.average),
                                64'(average_centi_kmh));
                    check_field("distance_mm", 64'(want.distance), 64'(distance_mm));
                    check_field("duration_ticks", 64'(want.duration), 64'(duration_ticks));
                    check_field("updated", 64'(want.advanced), 64'(updated));
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 150)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (results_seen >= 350 && results_seen < 450)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (revolutions_pending.size() != 0 || readings_due.size() != 0 || in_valid)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_circumference(input logic [wso_pkg::CIRC_W-1:0] value);
        begin
            wait_drained();
            @(posedge clk);
            cfg_valid              <= 1'b1;
            wheel_circumference_mm <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            circ_setting = value;
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        int unsigned                 roll;
        logic [wso_pkg::TICKS_W-1:0] ticks;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // stopped before any turn, first turn noted, zero ticks, extremes
        revolutions_pending.push_back(wso_pkg::TICKS_STOPPED);
        revolutions_pending.push_back(16'd300);
        revolutions_pending.push_back(16'd0);
        revolutions_pending.push_back(16'd1);
        revolutions_pending.push_back(16'd65534);
        revolutions_pending.push_back(wso_pkg::TICKS_STOPPED);
        revolutions_pending.push_back(16'd150);

        // largest wheel, speed saturates on zero-tick revolutions
        set_circumference(13'd8191);
        revolutions_pending.push_back(16'd0);
        revolutions_pending.push_back(16'd0);
        revolutions_pending.push_back(16'd0);
        revolutions_pending.push_back(16'd1);
        revolutions_pending.push_back(16'd7);

        // zero circumference
        set_circumference(13'd0);
        revolutions_pending.push_back(16'd200);
        revolutions_pending.push_back(16'd0);

        // smallest wheel
        set_circumference(13'd1);
        revolutions_pending.push_back(16'd65534);
        revolutions_pending.push_back(16'd3);

        for (int phase = 0; phase < 6; phase++)
        begin
            set_circumference(wso_pkg::CIRC_W'($urandom_range(1, 8191)));
            repeat (100)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    ticks = wso_pkg::TICKS_STOPPED;
                else if (roll < 12)
                    ticks = '0;
                else if (roll < 22)
                    ticks = wso_pkg::TICKS_W'($urandom);
                else
                    ticks = wso_pkg::TICKS_W'($urandom_range(40, 1200));
                revolutions_pending.push_back(ticks);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/wso_pkg.sv
hdl/wso_divider.sv
hdl/wheel_speed_odometer.sv
tb/wheel_speed_odometer_tb.sv
